// ===== src/arpc_pkg.sv =====
// Shared types, constants and helpers of the ARP cache.
package arpc_pkg;

    localparam int ENTRIES_PER_PORT = 256;
    localparam int NUM_PORTS        = 2;

    localparam int IDX_W  = $clog2(ENTRIES_PER_PORT);
    localparam int CNT_W  = $clog2(ENTRIES_PER_PORT + 1);
    localparam int ADDR_W = $clog2(NUM_PORTS * ENTRIES_PER_PORT);
    localparam int DEPTH  = NUM_PORTS * ENTRIES_PER_PORT;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_LEARN  = 2'd2;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic CFG_RESOLVED   = 1'b0;
    localparam logic CFG_UNRESOLVED = 1'b1;

    localparam logic [15:0] RESOLVED_TIMEOUT_RST   = 16'd60;
    localparam logic [15:0] UNRESOLVED_TIMEOUT_RST = 16'd1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] last_seen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic idle;
        logic accept;
        logic scan;
        logic fill;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic req_valid;
        logic start_scan;
        logic empty;
        logic hit;
        logic last;
        logic out_free;
    } stat_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic port, input logic [CNT_W-1:0] idx);
        return ADDR_W'(ADDR_W'(port) * ADDR_W'(ENTRIES_PER_PORT) + ADDR_W'(idx));
    endfunction

endpackage

// ===== src/arpc_if.sv =====
// Channel interfaces of the ARP cache: requests, results and configuration writes.
interface arpc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        port_index;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    modport source (output valid, command, port_index, ip_address, mac_address, input ready);
    modport sink (input valid, command, port_index, ip_address, mac_address, output ready);
endinterface

interface arpc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  entry_index;
    logic [47:0] mac_out;
    logic        resolved;
    logic        send_arp_request;
    logic        newly_added;
    logic        became_resolved;
    logic        table_full;
    modport source (output valid, entry_index, mac_out, resolved, send_arp_request,
                    newly_added, became_resolved, table_full, input ready);
    modport sink (input valid, entry_index, mac_out, resolved, send_arp_request,
                  newly_added, became_resolved, table_full, output ready);
endinterface

interface arpc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/arpc_ctrl.sv =====
// Sequencer of the ARP cache: accept, table scan, fill and result hand-off.
module arpc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  arpc_pkg::stat_t stat,
    output arpc_pkg::ctrl_t ctrl
);
    import arpc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.idle = 1'b1;
                if (stat.req_valid)
                begin
                    ctrl.accept = 1'b1;
                    if (stat.start_scan)
                    begin
                        state_next = stat.empty ? S_FILL : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_OUT;
                end
                else if (stat.last)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ctrl.fill  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== src/arpc_dp.sv =====
// Datapath of the ARP cache: entry RAM, scan evaluation, counters and result registers.
module arpc_dp (
    input  logic            clk,
    input  logic            rst_n,
    arpc_req_if.sink        req,
    arpc_rsp_if.source      rsp,
    arpc_cfg_if.sink        cfg,
    input  arpc_pkg::ctrl_t ctrl,
    output arpc_pkg::stat_t stat
);
    import arpc_pkg::*;

    logic             learn_reg;
    logic             port_reg;
    logic [31:0]      ip_reg;
    logic [47:0]      mac_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             have_free_reg, have_free_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [31:0]      now_reg;
    logic [15:0]      rto_reg, uto_reg;
    logic [CNT_W-1:0] used_reg [NUM_PORTS];

    logic [7:0]  res_idx_reg, res_idx_next;
    logic [47:0] res_mac_reg, res_mac_next;
    logic [4:0]  res_flags_reg, res_flags_next;

    logic        out_valid_reg;
    logic [7:0]  out_idx_reg;
    logic [47:0] out_mac_reg;
    logic [4:0]  out_flags_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    entry_t            wentry, rentry;
    logic [ENTRY_W-1:0] rdata;

    logic             live, stale, hit, last, full, port_ok;
    logic [31:0]      age;
    logic [IDX_W-1:0] fidx;
    logic [CNT_W-1:0] cnt_ext;

    arpc_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rentry  = entry_t'(rdata);
    assign port_ok = (32'(req.port_index) < 32'(NUM_PORTS));
    assign cnt_ext = CNT_W'(cnt_reg);

    assign stat.req_valid  = req.valid;
    assign stat.start_scan = port_ok && (req.command == CMD_LOOKUP || req.command == CMD_LEARN);
    assign stat.empty      = (used_reg[req.port_index] == '0);
    assign stat.hit        = hit;
    assign stat.last       = last;
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    assign req.ready = ctrl.idle;
    assign cfg.ready = 1'b1;

    // During the scan the RAM is always one entry ahead of the evaluation.
    assign raddr = ctrl.accept ? addr_of(req.port_index, '0) : addr_of(port_reg, cnt_ext + 1'b1);

    assign age  = now_reg - rentry.last_seen;
    assign live = (rentry.status == ST_OK) || (rentry.status == ST_WAIT);
    assign last = (cnt_ext + 1'b1 == n_reg);
    assign full = !have_free_reg && (n_reg == CNT_W'(ENTRIES_PER_PORT));
    assign fidx = have_free_reg ? free_reg : n_reg[IDX_W-1:0];

    always_comb
    begin
        if (rentry.status == ST_OK)
        begin
            stale = age > {16'd0, rto_reg};
        end
        else
        begin
            stale = age > {16'd0, uto_reg};
        end
    end

    always_comb
    begin
        we             = 1'b0;
        waddr          = addr_of(port_reg, cnt_ext);
        wentry         = rentry;
        hit            = 1'b0;
        cnt_next       = cnt_reg;
        have_free_next = have_free_reg;
        free_next      = free_reg;
        res_idx_next   = res_idx_reg;
        res_mac_next   = res_mac_reg;
        res_flags_next = res_flags_reg;
        if (ctrl.accept)
        begin
            cnt_next       = '0;
            have_free_next = 1'b0;
        end
        else if (ctrl.scan)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (live && rentry.ip == ip_reg && (learn_reg || rentry.status == ST_OK || !stale))
            begin
                hit          = 1'b1;
                res_idx_next = 8'(cnt_reg);
                // flags: resolved, send_arp_request, newly_added, became_resolved, table_full
                if (learn_reg)
                begin
                    we               = 1'b1;
                    wentry.status    = ST_OK;
                    wentry.mac       = mac_reg;
                    wentry.last_seen = (rentry.status == ST_OK) ? now_reg : rentry.last_seen;
                    res_mac_next     = mac_reg;
                    res_flags_next   = {1'b1, 1'b0, 1'b0, rentry.status == ST_WAIT, 1'b0};
                end
                else if (rentry.status == ST_OK)
                begin
                    we               = 1'b1;
                    wentry.last_seen = now_reg;
                    res_mac_next     = rentry.mac;
                    res_flags_next   = 5'b10000;
                end
                else
                begin
                    res_mac_next   = '0;
                    res_flags_next = 5'b01000;
                end
            end
            else if (!live || stale)
            begin
                if (live)
                begin
                    we            = 1'b1;
                    wentry.status = ST_FREE;
                end
                if (!have_free_reg)
                begin
                    have_free_next = 1'b1;
                    free_next      = cnt_reg;
                end
            end
        end
        else if (ctrl.fill)
        begin
            waddr            = addr_of(port_reg, CNT_W'(fidx));
            wentry.status    = learn_reg ? ST_OK : ST_WAIT;
            wentry.ip        = ip_reg;
            wentry.mac       = learn_reg ? mac_reg : 48'd0;
            wentry.last_seen = now_reg;
            if (full)
            begin
                res_idx_next   = '0;
                res_mac_next   = '0;
                res_flags_next = 5'b00001;
            end
            else
            begin
                we             = 1'b1;
                res_idx_next   = 8'(fidx);
                res_mac_next   = learn_reg ? mac_reg : 48'd0;
                res_flags_next = {learn_reg, !learn_reg, 1'b1, 1'b0, 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        free_reg      <= free_next;
        res_idx_reg   <= res_idx_next;
        res_mac_reg   <= res_mac_next;
        res_flags_reg <= res_flags_next;
        if (ctrl.accept)
        begin
            learn_reg <= (req.command == CMD_LEARN);
            port_reg  <= req.port_index;
            ip_reg    <= req.ip_address;
            mac_reg   <= req.mac_address;
            n_reg     <= used_reg[req.port_index];
        end
        if (ctrl.load_out)
        begin
            out_idx_reg   <= res_idx_reg;
            out_mac_reg   <= res_mac_reg;
            out_flags_reg <= res_flags_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_free_reg <= 1'b0;
            now_reg       <= '0;
            rto_reg       <= RESOLVED_TIMEOUT_RST;
            uto_reg       <= UNRESOLVED_TIMEOUT_RST;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                used_reg[p] <= '0;
            end
        end
        else
        begin
            have_free_reg <= have_free_next;
            if (ctrl.accept && req.command == CMD_TICK)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_RESOLVED:   rto_reg <= cfg.data;
                    CFG_UNRESOLVED: uto_reg <= cfg.data;
                endcase
            end
            // Appending a slot happens only when no freed slot was found.
            if (ctrl.fill && !full && !have_free_reg)
            begin
                used_reg[port_reg] <= n_reg + 1'b1;
            end
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.entry_index      = out_idx_reg;
    assign rsp.mac_out          = out_mac_reg;
    assign rsp.resolved         = out_flags_reg[4];
    assign rsp.send_arp_request = out_flags_reg[3];
    assign rsp.newly_added      = out_flags_reg[2];
    assign rsp.became_resolved  = out_flags_reg[1];
    assign rsp.table_full       = out_flags_reg[0];
endmodule

// ===== src/arp_cache_lookup_with_aging.sv =====
// Top level of the ARP cache with aging.
//
//   channel  role    beat carries
//   req      sink    command, port_index, ip_address, mac_address
//   rsp      source  entry_index, mac_out, resolved and the four flags
//   cfg      sink    register index and 16-bit timeout value
//
// A tick or an ignored command is accepted and gives no result beat. A lookup
// or learn is accepted, scans the used slots of its port until a hit (the RAM
// read port reads one entry per cycle), on a miss fills a slot or flags the
// table as full, and then loads the output register. Reset is asynchronous and
// needs no clearing pass. A stalled result beat waits in the output register.
module arp_cache_lookup_with_aging (
    input logic        clk,
    input logic        rst_n,
    arpc_req_if.sink   req,
    arpc_rsp_if.source rsp,
    arpc_cfg_if.sink   cfg
);
    import arpc_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    arpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    arpc_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctrl  (ctrl),
        .stat  (stat)
    );
endmodule

// ===== tb/arp_cache_lookup_with_aging_checker.sv =====
// Checker of the ARP cache: predicts each lookup and learn answer and compares it.
module arp_cache_lookup_with_aging_checker (
    input logic  clk,
    input logic  rst_n,
    arpc_req_if  req,
    arpc_rsp_if  rsp,
    arpc_cfg_if  cfg,
    output int   mismatches,
    output int   answers_waiting
);
    import arpc_pkg::*;

    typedef struct packed {
        logic [7:0]  entry_index;
        logic [47:0] mac_out;
        logic        resolved;
        logic        send_arp_request;
        logic        newly_added;
        logic        became_resolved;
        logic        table_full;
    } arp_answer_t;

    logic [1:0]  slot_status [DEPTH];
    logic [31:0] slot_ip     [DEPTH];
    logic [47:0] slot_mac    [DEPTH];
    logic [31:0] slot_seen   [DEPTH];
    int          slots_used  [NUM_PORTS];
    logic [31:0] now_sec;
    logic [15:0] resolved_limit;
    logic [15:0] unresolved_limit;

    arp_answer_t answers_due [$];

    function automatic bit aged_out(input int s);
        logic [31:0] age;
        age = now_sec - slot_seen[s];
        if (slot_status[s] == ST_OK)
            return age > 32'(resolved_limit);
        if (slot_status[s] == ST_WAIT)
            return age > 32'(unresolved_limit);
        return 1'b0;
    endfunction

    function automatic arp_answer_t make_answer(input int idx, input int s, input bit fresh,
                                                input bit woke, input bit full,
                                                input bit is_lookup);
        arp_answer_t a;
        bit ok;
        ok = !full && slot_status[s] == ST_OK;
        a.entry_index      = full ? 8'd0 : 8'(idx);
        a.mac_out          = ok ? slot_mac[s] : 48'd0;
        a.resolved         = ok;
        a.send_arp_request = !full && is_lookup && !ok;
        a.newly_added      = fresh;
        a.became_resolved  = woke;
        a.table_full       = full;
        return a;
    endfunction

    // Returns 1 when the beat produces an answer; updates the table as the block does.
    function automatic bit resolve_beat(input logic [1:0] cmd, input logic port,
                                        input logic [31:0] ip, input logic [47:0] mac,
                                        output arp_answer_t ans);
        bit learn;
        bit have_free;
        bit woke;
        int free_idx;
        int base;
        int n;
        int s;
        int idx;
        learn = (cmd == CMD_LEARN);
        have_free = 1'b0;
        free_idx = 0;
        ans = '0;
        if (cmd == CMD_TICK) begin
            now_sec = now_sec + 32'd1;
            return 1'b0;
        end
        if (cmd != CMD_LOOKUP && cmd != CMD_LEARN)
            return 1'b0;
        if (int'(port) >= NUM_PORTS)
            return 1'b0;
        base = int'(port) * ENTRIES_PER_PORT;
        n = slots_used[port];
        for (int i = 0; i < n; i++) begin
            s = base + i;
            if (slot_status[s] != ST_OK && slot_status[s] != ST_WAIT) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    free_idx = i;
                end
                continue;
            end
            if (slot_ip[s] == ip) begin
                if (slot_status[s] == ST_OK)
                    slot_seen[s] = now_sec;
                if (learn) begin
                    woke = (slot_status[s] == ST_WAIT);
                    slot_mac[s] = mac;
                    slot_status[s] = ST_OK;
                    ans = make_answer(i, s, 1'b0, woke, 1'b0, 1'b0);
                    return 1'b1;
                end
                if (!aged_out(s)) begin
                    ans = make_answer(i, s, 1'b0, 1'b0, 1'b0, 1'b1);
                    return 1'b1;
                end
            end else if (!aged_out(s)) begin
                continue;
            end
            // A stale entry is released and may be reused by this very beat.
            slot_status[s] = ST_FREE;
            if (!have_free) begin
                have_free = 1'b1;
                free_idx = i;
            end
        end
        if (have_free) begin
            idx = free_idx;
        end else if (n < ENTRIES_PER_PORT) begin
            idx = n;
            slots_used[port] = n + 1;
        end else begin
            ans = make_answer(0, base, 1'b0, 1'b0, 1'b1, !learn);
            return 1'b1;
        end
        s = base + idx;
        slot_ip[s] = ip;
        slot_status[s] = learn ? ST_OK : ST_WAIT;
        slot_mac[s] = learn ? mac : 48'd0;
        slot_seen[s] = now_sec;
        ans = make_answer(idx, s, 1'b1, 1'b0, 1'b0, !learn);
        return 1'b1;
    endfunction

    arp_answer_t predicted;
    arp_answer_t observed;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                slot_status[i] = ST_FREE;
                slot_ip[i] = '0;
                slot_mac[i] = '0;
                slot_seen[i] = '0;
            end
            for (int p = 0; p < NUM_PORTS; p++)
                slots_used[p] = 0;
            now_sec = '0;
            resolved_limit = RESOLVED_TIMEOUT_RST;
            unresolved_limit = UNRESOLVED_TIMEOUT_RST;
            answers_due.delete();
            mismatches = 0;
            answers_waiting = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_RESOLVED)
                    resolved_limit = cfg.data;
                else
                    unresolved_limit = cfg.data;
            end
            if (rsp.valid && rsp.ready) begin
                observed = {rsp.entry_index, rsp.mac_out, rsp.resolved, rsp.send_arp_request,
                            rsp.newly_added, rsp.became_resolved, rsp.table_full};
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected answer beat: idx=%0d mac=%h flags=%b",
                                 observed.entry_index, observed.mac_out, observed[4:0]);
                end else begin
                    predicted = answers_due.pop_front();
                    if (observed !== predicted) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp/got: idx %0d/%0d mac %h/%h flags %b/%b",
                                     predicted.entry_index, observed.entry_index,
                                     predicted.mac_out, observed.mac_out,
                                     predicted[4:0], observed[4:0]);
                    end
                end
            end
            if (req.valid && req.ready) begin
                if (resolve_beat(req.command, req.port_index, req.ip_address,
                                 req.mac_address, predicted))
                    answers_due.push_back(predicted);
            end
            answers_waiting = answers_due.size();
        end
    end

endmodule

// ===== tb/arp_cache_lookup_with_aging_tb.sv =====
// Testbench top of the ARP cache: drives requests and timeouts, and gives the verdict.
module arp_cache_lookup_with_aging_tb;
    import arpc_pkg::*;

    localparam int DRAIN_CYCLES = ENTRIES_PER_PORT + 16;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 330;

    // Command value that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   answers_waiting;
    int   cycles;
    int   send_calm;
    int   take_calm;
    int   take_hold;
    bit   answer_taken;
    logic [31:0] ip_pool [12];

    arpc_req_if req ();
    arpc_rsp_if rsp ();
    arpc_cfg_if cfg ();

    arp_cache_lookup_with_aging u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    arp_cache_lookup_with_aging_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .answers_waiting (answers_waiting)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Waits are mostly random, with occasional runs of back-to-back beats.
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    always @(posedge clk)
        answer_taken = rsp.valid && rsp.ready;

    always @(negedge clk) begin
        if (answer_taken) begin
            take_hold = draw_wait(take_calm);
            answer_taken = 1'b0;
        end
        if (take_hold > 0) begin
            rsp.ready = 1'b0;
            take_hold--;
        end else begin
            rsp.ready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(input logic [1:0] cmd, input logic port,
                                input logic [31:0] ip, input logic [47:0] mac);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.command = cmd;
        req.port_index = port;
        req.ip_address = ip;
        req.mac_address = mac;
        req.valid = 1'b1;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    task automatic settle;
        req.valid = 1'b0;
        @(negedge clk);
        while (answers_waiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(input logic index, input logic [15:0] value);
        cfg.index = index;
        cfg.data = value;
        cfg.valid = 1'b1;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic random_phase(input int count);
        int pick;
        logic [47:0] mac;
        for (int i = 0; i < 12; i++)
            ip_pool[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            mac = {16'($urandom), 32'($urandom)};
            if (pick < 25)
                send_request(CMD_TICK, 1'($urandom), $urandom, mac);
            else if (pick < 60)
                send_request(CMD_LOOKUP, 1'($urandom), ip_pool[$urandom_range(0, 11)], mac);
            else if (pick < 95)
                send_request(CMD_LEARN, 1'($urandom), ip_pool[$urandom_range(0, 11)], mac);
            else if (pick < 98)
                send_request(CMD_UNUSED, 1'($urandom), $urandom, mac);
            else
                send_request(CMD_LOOKUP, 1'($urandom), $urandom, mac);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.command = CMD_TICK;
        req.port_index = 1'b0;
        req.ip_address = '0;
        req.mac_address = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_RESOLVED;
        cfg.data = '0;
        rsp.ready = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: miss, unresolved hit, unresolved ageing, wake-up by learn, extremes.
        send_request(CMD_LOOKUP, 1'b0, 32'h0A00_0001, 48'd0);
        send_request(CMD_LOOKUP, 1'b0, 32'h0A00_0001, 48'd0);
        send_request(CMD_TICK, 1'b0, 32'd0, 48'd0);
        send_request(CMD_TICK, 1'b1, 32'd0, 48'd0);
        send_request(CMD_LOOKUP, 1'b0, 32'h0A00_0001, 48'd0);
        send_request(CMD_LEARN, 1'b0, 32'h0A00_0001, 48'h0011_2233_4455);
        send_request(CMD_LOOKUP, 1'b0, 32'h0A00_0001, 48'd0);
        send_request(CMD_LEARN, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_LEARN, 1'b1, 32'h0000_0000, 48'h0000_0000_0000);
        send_request(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_LOOKUP, 1'b1, 32'hFFFF_FFFF, 48'd0);
        send_request(CMD_LEARN, 1'b1, 32'hFFFF_FFFF, 48'hA5A5_5A5A_0F0F);
        send_request(CMD_LOOKUP, 1'b1, 32'h0000_0000, 48'd0);
        // A stale unresolved entry is still woken by a learn.
        send_request(CMD_LOOKUP, 1'b0, 32'hC0A8_0001, 48'd0);
        send_request(CMD_TICK, 1'b0, 32'd0, 48'd0);
        send_request(CMD_TICK, 1'b0, 32'd0, 48'd0);
        send_request(CMD_LEARN, 1'b0, 32'hC0A8_0001, 48'h8000_0000_0001);
        send_request(CMD_LOOKUP, 1'b0, 32'h0A00_0001, 48'd0);
        settle();

        // Short timeouts: resolved entries go stale and are freed by lookups and learns.
        write_timeout(CFG_RESOLVED, 16'd1);
        write_timeout(CFG_UNRESOLVED, 16'd1);
        random_phase(RANDOM_ITEMS);
        settle();

        // Nothing ages; fill one port's table until it overflows.
        write_timeout(CFG_RESOLVED, 16'hFFFF);
        write_timeout(CFG_UNRESOLVED, 16'hFFFF);
        for (int i = 0; i < ENTRIES_PER_PORT + 2; i++)
            send_request(CMD_LEARN, 1'b0, {16'hBEEF, 16'(i)}, {16'($urandom), 32'($urandom)});
        send_request(CMD_LOOKUP, 1'b0, 32'hDEAD_0001, 48'd0);
        send_request(CMD_LEARN, 1'b0, {16'hBEEF, 16'd7}, 48'h1234_5678_9ABC);
        random_phase(RANDOM_ITEMS);
        settle();

        write_timeout(CFG_RESOLVED, 16'd3);
        write_timeout(CFG_UNRESOLVED, 16'd2);
        random_phase(RANDOM_ITEMS);
        settle();

        write_timeout(CFG_RESOLVED, 16'($urandom_range(1, 12)));
        write_timeout(CFG_UNRESOLVED, 16'($urandom_range(1, 6)));
        random_phase(RANDOM_ITEMS);
        settle();

        write_timeout(CFG_RESOLVED, 16'($urandom_range(1, 65535)));
        write_timeout(CFG_UNRESOLVED, 16'($urandom_range(1, 65535)));
        random_phase(RANDOM_ITEMS / 2);
        settle();

        write_timeout(CFG_RESOLVED, RESOLVED_TIMEOUT_RST);
        write_timeout(CFG_UNRESOLVED, UNRESOLVED_TIMEOUT_RST);
        random_phase(RANDOM_ITEMS / 2);
        settle();

        if (mismatches == 0 && answers_waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/arpc_pkg.sv
src/arpc_if.sv
src/arpc_ram.sv
src/arpc_ctrl.sv
src/arpc_dp.sv
src/arp_cache_lookup_with_aging.sv
tb/arp_cache_lookup_with_aging_checker.sv
tb/arp_cache_lookup_with_aging_tb.sv
